@@ rtl/bpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfm_pkg
// shared types and codes of the buffer pool frame manager
// ----------------------------------------------------------------------------
package bpfm_pkg;

    // number of buffer frames; frame fields and ports are four bits wide
    localparam int FRAMES = 16;

    // command codes
    localparam logic [2:0] CMD_FETCH  = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_DIRTY  = 3'd2;
    localparam logic [2:0] CMD_UNPIN  = 3'd3;
    localparam logic [2:0] CMD_FLUSH  = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_FRAME = 2'd1;
    localparam logic [1:0] STAT_NO_DIRTY = 2'd2;

    // directory slot tags
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // fnv-1a 64-bit offset basis; the prime 2^40 + 435 is applied by shift-add
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HASH,
        ST_PRB_RD,
        ST_PRB_CHK,
        ST_FR_RD,
        ST_FR_CHK,
        ST_HD_RD,
        ST_HD_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_FILL,
        ST_MD_RD,
        ST_MD_WR,
        ST_FL_RD,
        ST_FL_CHK,
        ST_FL_EMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        used;
        logic [15:0] tab;
        logic [31:0] blk;
        logic        dirty;
        logic        pinned;
    } frame_entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  frame;
        logic        read_needed;
        logic        evicted;
        logic        writeback;
        logic [15:0] wb_table;
        logic [31:0] wb_block;
        logic        last;
    } res_t;

endpackage

@@ rtl/buffer_pool_frame_manager_core.sv @@
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_core
// maps (table, block) keys to buffer frames with a hashed directory and
// round-robin replacement
// ----------------------------------------------------------------------------
// mark dirty / unpin read and write the frame entry when its index is in range; fetch
//   hashes the key and probes the directory; a miss adds the free search and the hand
//   sweep, a victim rehash and probe for the victim slot, insert probe, fill, result
// flush: reads each frame examined and returns one result per dirty frame; one
//   transaction at a time, set by the hash unit and the one-port memories
// reset: synchronous, active low; clears control, valid bits and hand, no sweep
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_core #(
    parameter int DIR_SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [15:0] s_table_id,
    input  logic [31:0] s_block_id,
    input  logic [3:0]  s_frame_index,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_hit,
    output logic [3:0]  m_frame,
    output logic        m_read_needed,
    output logic        m_evicted,
    output logic        m_writeback,
    output logic [15:0] m_wb_table,
    output logic [31:0] m_wb_block,
    output logic        m_last
);
    import bpfm_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int NW = $clog2(FRAMES + 1);
    localparam int SW = $clog2(DIR_SLOTS);
    localparam int PW = $clog2(DIR_SLOTS + 1);

    typedef struct packed {
        logic [1:0]    tag;
        logic [15:0]   tab;
        logic [31:0]   blk;
        logic [FW-1:0] fr;
    } dir_entry_t;

    // memories and their valid bits (an entry never written reads as reset)
    frame_entry_t fmem [FRAMES];
    logic [FRAMES-1:0] fval_reg;
    dir_entry_t dmem [DIR_SLOTS];
    logic [DIR_SLOTS-1:0] dval_reg;

    frame_entry_t f_rd_reg;
    logic         f_rdv_reg;
    dir_entry_t   d_rd_reg;
    logic         d_rdv_reg;

    // memory port controls
    logic          f_rd_en, f_wr_en, d_rd_en, d_wr_en;
    logic [FW-1:0] f_rd_addr, f_wr_addr;
    frame_entry_t  f_wr_data;
    logic [SW-1:0] d_rd_addr, d_wr_addr;
    dir_entry_t    d_wr_data;

    // sequencer state
    state_t        state_reg, state_next;
    logic [4:0]    fiu_reg;
    logic [NW-1:0] hand_reg, hand_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [15:0]   tab_reg, tab_next;
    logic [31:0]   blk_reg, blk_next;
    logic [3:0]    fi_reg, fi_next;
    logic [SW-1:0] home_reg, home_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0] fr_reg, fr_next;
    frame_entry_t  vic_reg, vic_next;
    logic          vmode_reg, vmode_next;
    res_t          rslt_reg, rslt_next;
    logic          pend_reg, pend_next;
    logic [4:0]    k_reg, k_next;
    res_t          out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    // hash unit
    logic          hs_start, hs_done;
    logic [15:0]   hs_tab;
    logic [31:0]   hs_blk;
    logic [SW-1:0] hs_slot;

    logic          accept;
    logic          out_free;
    logic [NW-1:0] n_w;
    frame_entry_t  fent;
    dir_entry_t    dent;
    logic [SW-1:0] slot_inc;
    logic [15:0]   cmp_tab;
    logic [31:0]   cmp_blk;
    logic          key_match;
    logic          vic_wb;

    bpfm_hash #(.DIR_SLOTS(DIR_SLOTS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hs_start),
        .tab     (hs_tab),
        .blk     (hs_blk),
        .done    (hs_done),
        .slot    (hs_slot)
    );

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    // a waiting result leaves the output register free once it is taken
    assign out_free = !m_valid_reg || m_ready;
    // managed frame count, clipped to the pool size
    assign n_w = (8'(fiu_reg) > 8'(FRAMES)) ? NW'(FRAMES) : NW'(fiu_reg);

    assign fent = f_rdv_reg ? f_rd_reg : '0;
    assign dent = d_rdv_reg ? d_rd_reg : '0;

    assign slot_inc  = (slot_reg == SW'(DIR_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    // lookup compares the requested key, victim search the evicted page's key
    assign cmp_tab   = vmode_reg ? vic_reg.tab : tab_reg;
    assign cmp_blk   = vmode_reg ? vic_reg.blk : blk_reg;
    assign key_match = (dent.tab == cmp_tab) && (dent.blk == cmp_blk)
                    && (!vmode_reg || dent.fr == fr_reg);
    assign vic_wb    = vic_reg.used && vic_reg.dirty;

    // hash key is taken from the ports at accept, from the victim at sweep
    assign hs_tab = (state_reg == ST_IDLE) ? s_table_id : fent.tab;
    assign hs_blk = (state_reg == ST_IDLE) ? s_block_id : fent.blk;

    always_comb begin
        state_next   = state_reg;
        hand_next    = hand_reg;
        cmd_next     = cmd_reg;
        tab_next     = tab_reg;
        blk_next     = blk_reg;
        fi_next      = fi_reg;
        home_next    = home_reg;
        slot_next    = slot_reg;
        pcnt_next    = pcnt_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        fr_next      = fr_reg;
        vic_next     = vic_reg;
        vmode_next   = vmode_reg;
        rslt_next    = rslt_reg;
        pend_next    = pend_reg;
        k_next       = k_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        hs_start     = 1'b0;
        f_rd_en      = 1'b0;
        f_rd_addr    = idx_reg[FW-1:0];
        f_wr_en      = 1'b0;
        f_wr_addr    = fr_reg;
        f_wr_data    = fent;
        d_rd_en      = 1'b0;
        d_rd_addr    = slot_reg;
        d_wr_en      = 1'b0;
        d_wr_addr    = slot_reg;
        d_wr_data    = dent;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next   = s_cmd;
                    tab_next   = s_table_id;
                    blk_next   = s_block_id;
                    fi_next    = s_frame_index;
                    vmode_next = 1'b0;
                    rslt_next  = '0;
                    rslt_next.last = 1'b1;
                    unique case (s_cmd) inside
                        CMD_FETCH, CMD_CREATE: begin
                            hs_start   = 1'b1;
                            state_next = ST_HASH;
                        end
                        CMD_DIRTY, CMD_UNPIN: begin
                            rslt_next.frame = s_frame_index;
                            if (8'(s_frame_index) < 8'(n_w)) begin
                                state_next = ST_MD_RD;
                            end else begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_FLUSH: begin
                            idx_next   = '0;
                            k_next     = '0;
                            pend_next  = 1'b0;
                            state_next = ST_FL_RD;
                        end
                        default: begin
                            // unknown command: dropped, no result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_HASH: begin
                if (hs_done) begin
                    pcnt_next = '0;
                    if (vmode_reg) begin
                        slot_next  = hs_slot;
                        state_next = ST_PRB_RD;
                    end else begin
                        home_next = hs_slot;
                        if (cmd_reg == CMD_FETCH) begin
                            slot_next  = hs_slot;
                            state_next = ST_PRB_RD;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_FR_RD;
                        end
                    end
                end
            end

            // linear probe, shared by lookup and victim slot search
            ST_PRB_RD: begin
                if (pcnt_reg == PW'(DIR_SLOTS)) begin
                    if (vmode_reg) begin
                        slot_next  = home_reg;
                        pcnt_next  = '0;
                        state_next = ST_INS_RD;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_FR_RD;
                    end
                end else begin
                    d_rd_en    = 1'b1;
                    state_next = ST_PRB_CHK;
                end
            end

            ST_PRB_CHK: begin
                if (dent.tag == SLOT_EMPTY) begin
                    if (vmode_reg) begin
                        slot_next  = home_reg;
                        pcnt_next  = '0;
                        state_next = ST_INS_RD;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_FR_RD;
                    end
                end else if (dent.tag == SLOT_USED && key_match) begin
                    if (vmode_reg) begin
                        // tombstone the victim's own mapping
                        d_wr_en       = 1'b1;
                        d_wr_data.tag = SLOT_TOMB;
                        slot_next     = home_reg;
                        pcnt_next     = '0;
                        state_next    = ST_INS_RD;
                    end else begin
                        rslt_next.hit   = 1'b1;
                        rslt_next.frame = 4'(dent.fr);
                        state_next      = ST_EMIT;
                    end
                end else begin
                    slot_next  = slot_inc;
                    pcnt_next  = pcnt_reg + 1'b1;
                    state_next = ST_PRB_RD;
                end
            end

            // lowest free frame below the managed count
            ST_FR_RD: begin
                if (idx_reg == n_w) begin
                    idx_next   = (hand_reg < n_w) ? hand_reg : '0;
                    cnt_next   = '0;
                    state_next = ST_HD_RD;
                end else begin
                    f_rd_en    = 1'b1;
                    state_next = ST_FR_CHK;
                end
            end

            ST_FR_CHK: begin
                if (!fent.used) begin
                    fr_next    = idx_reg[FW-1:0];
                    vic_next   = '0;
                    slot_next  = home_reg;
                    pcnt_next  = '0;
                    state_next = ST_INS_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FR_RD;
                end
            end

            // round-robin hand over pinned frames
            ST_HD_RD: begin
                if (cnt_reg == n_w) begin
                    rslt_next.status = STAT_NO_FRAME;
                    state_next       = ST_EMIT;
                end else begin
                    f_rd_en    = 1'b1;
                    state_next = ST_HD_CHK;
                end
            end

            ST_HD_CHK: begin
                if (!fent.pinned) begin
                    fr_next   = idx_reg[FW-1:0];
                    hand_next = idx_reg + 1'b1;
                    vic_next  = fent;
                    if (fent.used) begin
                        hs_start   = 1'b1;
                        vmode_next = 1'b1;
                        state_next = ST_HASH;
                    end else begin
                        slot_next  = home_reg;
                        pcnt_next  = '0;
                        state_next = ST_INS_RD;
                    end
                end else begin
                    idx_next   = (idx_reg + 1'b1 < n_w) ? idx_reg + 1'b1 : '0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_HD_RD;
                end
            end

            // first empty or tombstone slot from home; full directory skips
            ST_INS_RD: begin
                if (pcnt_reg == PW'(DIR_SLOTS)) begin
                    state_next = ST_FILL;
                end else begin
                    d_rd_en    = 1'b1;
                    state_next = ST_INS_CHK;
                end
            end

            ST_INS_CHK: begin
                if (dent.tag != SLOT_USED) begin
                    d_wr_en    = 1'b1;
                    d_wr_data  = '{tag: SLOT_USED, tab: tab_reg, blk: blk_reg, fr: fr_reg};
                    state_next = ST_FILL;
                end else begin
                    slot_next  = slot_inc;
                    pcnt_next  = pcnt_reg + 1'b1;
                    state_next = ST_INS_RD;
                end
            end

            ST_FILL: begin
                f_wr_en   = 1'b1;
                f_wr_data = '{used: 1'b1, tab: tab_reg, blk: blk_reg,
                              dirty: (cmd_reg == CMD_CREATE), pinned: 1'b1};
                rslt_next.frame       = 4'(fr_reg);
                rslt_next.read_needed = (cmd_reg != CMD_CREATE);
                rslt_next.evicted     = vic_reg.used;
                rslt_next.writeback   = vic_wb;
                rslt_next.wb_table    = vic_wb ? vic_reg.tab : 16'd0;
                rslt_next.wb_block    = vic_wb ? vic_reg.blk : 32'd0;
                state_next            = ST_EMIT;
            end

            // mark dirty / unpin read-modify-write
            ST_MD_RD: begin
                f_rd_en    = 1'b1;
                f_rd_addr  = fi_reg[FW-1:0];
                state_next = ST_MD_WR;
            end

            ST_MD_WR: begin
                f_wr_en   = 1'b1;
                f_wr_addr = fi_reg[FW-1:0];
                if (cmd_reg == CMD_DIRTY) begin
                    f_wr_data.dirty = 1'b1;
                end else begin
                    f_wr_data.pinned = 1'b0;
                end
                state_next = ST_EMIT;
            end

            // flush: one result held back so the final one carries last
            ST_FL_RD: begin
                if (idx_reg == n_w || k_reg == 5'(MAX_RESULTS)) begin
                    if (pend_reg) begin
                        rslt_next.last = 1'b1;
                    end else begin
                        rslt_next        = '0;
                        rslt_next.status = STAT_NO_DIRTY;
                        rslt_next.last   = 1'b1;
                    end
                    state_next = ST_EMIT;
                end else begin
                    f_rd_en    = 1'b1;
                    state_next = ST_FL_CHK;
                end
            end

            ST_FL_CHK: begin
                if (fent.used && fent.dirty) begin
                    f_wr_en         = 1'b1;
                    f_wr_addr       = idx_reg[FW-1:0];
                    f_wr_data.dirty = 1'b0;
                    if (pend_reg) begin
                        state_next = ST_FL_EMIT;
                    end else begin
                        rslt_next           = '0;
                        rslt_next.frame     = 4'(idx_reg);
                        rslt_next.writeback = 1'b1;
                        rslt_next.wb_table  = fent.tab;
                        rslt_next.wb_block  = fent.blk;
                        pend_next           = 1'b1;
                        k_next              = k_reg + 1'b1;
                        idx_next            = idx_reg + 1'b1;
                        state_next          = ST_FL_RD;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FL_RD;
                end
            end

            ST_FL_EMIT: begin
                if (out_free) begin
                    out_next            = rslt_reg;
                    m_valid_next        = 1'b1;
                    rslt_next           = '0;
                    rslt_next.frame     = 4'(idx_reg);
                    rslt_next.writeback = 1'b1;
                    rslt_next.wb_table  = fent.tab;
                    rslt_next.wb_block  = fent.blk;
                    k_next              = k_reg + 1'b1;
                    idx_next            = idx_reg + 1'b1;
                    state_next          = ST_FL_RD;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_next     = rslt_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fiu_reg     <= 5'd16;
            hand_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            vmode_reg   <= 1'b0;
            fval_reg    <= '0;
            dval_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            hand_reg    <= hand_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            vmode_reg   <= vmode_next;
            if (cfg_wr_en) begin
                fiu_reg <= cfg_wr_data;
            end
            if (f_wr_en) begin
                fval_reg[f_wr_addr] <= 1'b1;
            end
            if (d_wr_en) begin
                dval_reg[d_wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        tab_reg  <= tab_next;
        blk_reg  <= blk_next;
        fi_reg   <= fi_next;
        home_reg <= home_next;
        slot_reg <= slot_next;
        pcnt_reg <= pcnt_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        fr_reg   <= fr_next;
        vic_reg  <= vic_next;
        rslt_reg <= rslt_next;
        k_reg    <= k_next;
        out_reg  <= out_next;
    end

    // frame table memory, registered read
    always_ff @(posedge aclk) begin
        if (f_wr_en) begin
            fmem[f_wr_addr] <= f_wr_data;
        end
        if (f_rd_en) begin
            f_rd_reg  <= fmem[f_rd_addr];
            f_rdv_reg <= fval_reg[f_rd_addr];
        end
    end

    // key directory memory, registered read
    always_ff @(posedge aclk) begin
        if (d_wr_en) begin
            dmem[d_wr_addr] <= d_wr_data;
        end
        if (d_rd_en) begin
            d_rd_reg  <= dmem[d_rd_addr];
            d_rdv_reg <= dval_reg[d_rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_hit         = out_reg.hit;
    assign m_frame       = out_reg.frame;
    assign m_read_needed = out_reg.read_needed;
    assign m_evicted     = out_reg.evicted;
    assign m_writeback   = out_reg.writeback;
    assign m_wb_table    = out_reg.wb_table;
    assign m_wb_block    = out_reg.wb_block;
    assign m_last        = out_reg.last;

    // a known command always leaves idle: the block is not ready in the cycle after accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd <= CMD_FLUSH) |=> !s_ready)
        else $error("block still ready after accepting a command");

    // a result staged for output lands in the output register
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT || state_reg == ST_FL_EMIT) && out_free) |=> m_valid)
        else $error("staged result not loaded");

    // the hand never exceeds the pool size
    a_hand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hand_reg <= NW'(FRAMES))
        else $error("clock hand out of range");

    // the hash unit only completes while the sequencer waits for it
    a_hash_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_done |-> (state_reg == ST_HASH))
        else $error("hash finished outside its wait state");

endmodule

@@ rtl/bpfm_hash.sv @@
// ----------------------------------------------------------------------------
// bpfm_hash
// fnv-1a over the six key bytes and two zero bytes, then reduction to a directory slot
// ----------------------------------------------------------------------------
module bpfm_hash #(
    parameter int DIR_SLOTS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [15:0]                  tab,
    input  logic [31:0]                  blk,
    output logic                         done,
    output logic [$clog2(DIR_SLOTS)-1:0] slot
);
    import bpfm_pkg::*;

    localparam int SW = $clog2(DIR_SLOTS);

    logic          run_reg;
    logic          done_reg;
    logic [3:0]    step_reg;
    logic [63:0]   h_reg;
    logic [47:0]   key_reg;
    logic [SW-1:0] r_reg;

    logic [63:0]   h_x;
    logic [63:0]   h_mul;
    logic [SW:0]   t;

    always_comb begin
        h_x   = h_reg ^ {56'd0, key_reg[7:0]};
        h_mul = (h_x << 40) + (h_x << 8) + (h_x << 7) + (h_x << 5)
              + (h_x << 4) + (h_x << 1) + h_x;
        // eight bits of restoring reduction per cycle
        t = {1'b0, r_reg};
        for (int k = 0; k < 8; k++) begin
            t = {t[SW-1:0], h_reg[63-k]};
            if (t >= (SW+1)'(DIR_SLOTS)) begin
                t = t - (SW+1)'(DIR_SLOTS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 4'd15) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            h_reg   <= FNV_BASIS;
            key_reg <= {tab, blk};
            r_reg   <= '0;
        end else if (run_reg) begin
            if (!step_reg[3]) begin
                h_reg   <= h_mul;
                key_reg <= key_reg >> 8;
            end else begin
                h_reg <= h_reg << 8;
                r_reg <= t[SW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign slot = r_reg;

endmodule

@@ bench/tb_buffer_pool_frame_manager_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buffer_pool_frame_manager_core
// self-checking bench for the buffer pool frame manager: a directed table of
// commands, then random fetch/create/dirty/unpin/flush and unknown-code traffic under several
// frame counts, each result checked against a behavioral frame/directory model
// ----------------------------------------------------------------------------
module tb_buffer_pool_frame_manager_core;
    import bpfm_pkg::*;

    localparam int NFR = 16;
    localparam int NSLOT = 32;
    localparam logic [63:0] HASH_MUL = 64'd1099511628211;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [15:0] s_table_id = '0;
    logic [31:0] s_block_id = '0;
    logic [3:0]  s_frame_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_hit;
    logic [3:0]  m_frame;
    logic        m_read_needed;
    logic        m_evicted;
    logic        m_writeback;
    logic [15:0] m_wb_table;
    logic [31:0] m_wb_block;
    logic        m_last;

    buffer_pool_frame_manager_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_table_id(s_table_id), .s_block_id(s_block_id),
        .s_frame_index(s_frame_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_hit(m_hit),
        .m_frame(m_frame), .m_read_needed(m_read_needed), .m_evicted(m_evicted),
        .m_writeback(m_writeback), .m_wb_table(m_wb_table),
        .m_wb_block(m_wb_block), .m_last(m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- model state ----------------
    frame_entry_t pool [NFR];
    logic [1:0]   slot_tag [NSLOT];
    logic [15:0]  slot_tab [NSLOT];
    logic [31:0]  slot_blk [NSLOT];
    logic [3:0]   slot_fr [NSLOT];
    int           hand;
    int           n_frames;

    res_t expected_q[$];
    int   errors = 0;
    int   results_seen = 0;
    int   tx_sent = 0;
    int   src_idle_pct = 0;
    int   dst_idle_pct = 0;

    // fnv-1a over block bytes (le), table bytes (le), two zeros
    function automatic int home_of(logic [15:0] tab, logic [31:0] blk);
        logic [63:0] h;
        logic [7:0]  b [8];
        h = 64'hcbf29ce484222325;
        b[0] = blk[7:0]; b[1] = blk[15:8]; b[2] = blk[23:16]; b[3] = blk[31:24];
        b[4] = tab[7:0]; b[5] = tab[15:8]; b[6] = 8'h0; b[7] = 8'h0;
        for (int i = 0; i < 8; i++) begin
            h = (h ^ {56'h0, b[i]}) * HASH_MUL;
        end
        return int'(h % NSLOT);
    endfunction

    // slot holding the key (optionally for one frame), or NSLOT
    function automatic int lookup_slot(logic [15:0] tab, logic [31:0] blk, int fr_want);
        int s;
        s = home_of(tab, blk);
        for (int j = 0; j < NSLOT; j++) begin
            if (slot_tag[s] == SLOT_EMPTY) return NSLOT;
            if (slot_tag[s] == SLOT_USED && slot_tab[s] == tab && slot_blk[s] == blk
                && (fr_want >= NFR || int'(slot_fr[s]) == fr_want)) return s;
            s = (s + 1) % NSLOT;
        end
        return NSLOT;
    endfunction

    function automatic res_t blank_res();
        res_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // take a free frame or evict under the hand; record mapping
    function automatic void place_page(logic [15:0] tab, logic [31:0] blk, bit is_create);
        res_t r;
        int fr, h, s;
        r = blank_res();
        fr = NFR;
        for (int i = 0; i < n_frames; i++) begin
            if (!pool[i].used) begin
                fr = i;
                break;
            end
        end
        if (fr >= NFR) begin
            h = (hand < n_frames) ? hand : 0;
            for (int i = 0; i < n_frames; i++) begin
                if (!pool[h].pinned) begin
                    fr = h;
                    break;
                end
                h = (h + 1 < n_frames) ? h + 1 : 0;
            end
            if (fr >= NFR) begin
                r.status = STAT_NO_FRAME;
                expected_q.push_back(r);
                return;
            end
            hand = fr + 1;
            if (pool[fr].used) begin
                s = lookup_slot(pool[fr].tab, pool[fr].blk, fr);
                if (s < NSLOT) slot_tag[s] = SLOT_TOMB;
                r.evicted = 1'b1;
                if (pool[fr].dirty) begin
                    r.writeback = 1'b1;
                    r.wb_table = pool[fr].tab;
                    r.wb_block = pool[fr].blk;
                end
            end
        end
        s = home_of(tab, blk);
        for (int j = 0; j < NSLOT; j++) begin
            if (slot_tag[s] != SLOT_USED) begin
                slot_tag[s] = SLOT_USED;
                slot_tab[s] = tab;
                slot_blk[s] = blk;
                slot_fr[s] = 4'(fr);
                break;
            end
            s = (s + 1) % NSLOT;
        end
        pool[fr] = '{used: 1'b1, tab: tab, blk: blk, dirty: is_create, pinned: 1'b1};
        r.frame = 4'(fr);
        r.read_needed = !is_create;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_cmd(logic [2:0] cmd, logic [15:0] tab,
                                        logic [31:0] blk, logic [3:0] fi);
        res_t r;
        int s, k;
        r = blank_res();
        case (cmd) inside
            CMD_FETCH: begin
                s = lookup_slot(tab, blk, NFR);
                if (s < NSLOT) begin
                    r.hit = 1'b1;
                    r.frame = slot_fr[s];
                    expected_q.push_back(r);
                end else begin
                    place_page(tab, blk, 1'b0);
                end
            end
            CMD_CREATE: place_page(tab, blk, 1'b1);
            CMD_DIRTY, CMD_UNPIN: begin
                if (int'(fi) < n_frames) begin
                    if (cmd == CMD_DIRTY) pool[fi].dirty = 1'b1;
                    else pool[fi].pinned = 1'b0;
                end
                r.frame = fi;
                expected_q.push_back(r);
            end
            CMD_FLUSH: begin
                k = 0;
                for (int i = 0; i < n_frames && k < MAX_RESULTS; i++) begin
                    if (pool[i].used && pool[i].dirty) begin
                        r = '0;
                        r.frame = 4'(i);
                        r.writeback = 1'b1;
                        r.wb_table = pool[i].tab;
                        r.wb_block = pool[i].blk;
                        pool[i].dirty = 1'b0;
                        expected_q.push_back(r);
                        k++;
                    end
                end
                if (k == 0) begin
                    r = blank_res();
                    r.status = STAT_NO_DIRTY;
                    expected_q.push_back(r);
                end else begin
                    expected_q[$].last = 1'b1;
                end
            end
            default: ;  // unknown codes produce nothing
        endcase
    endfunction

    // ---------------- result checker ----------------
    res_t got;
    assign got = '{status: m_status, hit: m_hit, frame: m_frame,
                   read_needed: m_read_needed, evicted: m_evicted,
                   writeback: m_writeback, wb_table: m_wb_table,
                   wb_block: m_wb_block, last: m_last};

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors <= errors + 1;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // ---------------- stimulus ----------------
    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] tab;
        logic [31:0] blk;
        logic [3:0]  fi;
        bit          typed;  // expected result given in the row
        res_t        res;
    } stim_row_t;

    stim_row_t rows [$];
    logic [15:0] hot_tab [8];
    logic [31:0] hot_blk [8];

    function automatic res_t mk(logic [1:0] st, logic [3:0] fr, bit rd);
        res_t r;
        r = blank_res();
        r.status = st;
        r.frame = fr;
        r.read_needed = rd;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] c, logic [15:0] t, logic [31:0] b,
                                    logic [3:0] f, bit typed, res_t r);
        rows.push_back('{cmd: c, tab: t, blk: b, fi: f, typed: typed, res: r});
    endfunction

    // drive one transaction and hold it until accepted; valid drops only while idling
    task automatic send_cmd(logic [2:0] c, logic [15:0] t, logic [31:0] b, logic [3:0] f);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_table_id <= t;
        s_block_id <= b;
        s_frame_index <= f;
        do @(posedge aclk); while (!s_ready);
        predict_cmd(c, t, b, f);
        tx_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);  // lets an ignored command finish too
    endtask

    task automatic set_frames(logic [4:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_frames = (v > NFR) ? NFR : int'(v);
        @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int pick, k;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            k = $urandom_range(7);
            if (pick < 35)       // reuse of a hot key gives hits
                send_cmd(CMD_FETCH, hot_tab[k], hot_blk[k], 4'($urandom));
            else if (pick < 45)
                send_cmd(CMD_FETCH, 16'($urandom), $urandom, 4'($urandom));
            else if (pick < 55)
                send_cmd(CMD_CREATE, hot_tab[k], hot_blk[k], 4'($urandom));
            else if (pick < 68)
                send_cmd(CMD_DIRTY, 16'($urandom), $urandom, 4'($urandom));
            else if (pick < 90)
                send_cmd(CMD_UNPIN, 16'($urandom), $urandom, 4'($urandom));
            else if (pick < 96)
                send_cmd(CMD_FLUSH, 16'($urandom), $urandom, 4'($urandom));
            else
                send_cmd(3'($urandom_range(7, 5)), 16'($urandom), $urandom, 4'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < NFR; i++) pool[i] = '0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_tag[i] = SLOT_EMPTY;
            slot_tab[i] = '0;
            slot_blk[i] = '0;
            slot_fr[i] = '0;
        end
        hand = 0;
        n_frames = NFR;
        for (int i = 0; i < 8; i++) begin
            hot_tab[i] = (i < 2) ? {16{i[0]}} : 16'($urandom);
            hot_blk[i] = (i < 2) ? {32{i[0]}} : $urandom;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: two frames managed so pinning and eviction show up fast
        set_frames(5'd2);
        add_row(CMD_FLUSH, 0, 0, 0, 1, mk(STAT_NO_DIRTY, 0, 0));
        add_row(CMD_FETCH, 16'h0000, 32'h0000_0000, 0, 1, mk(STAT_OK, 0, 1));
        add_row(CMD_CREATE, 16'hffff, 32'hffff_ffff, 0, 0, '0);
        add_row(CMD_FETCH, 16'h0000, 32'h0000_0000, 0, 0, '0);
        // both pinned: no frame
        add_row(CMD_FETCH, 16'h1234, 32'h5678_9abc, 0, 1, mk(STAT_NO_FRAME, 0, 0));
        add_row(CMD_UNPIN, 0, 0, 4'd15, 1, mk(STAT_OK, 4'd15, 0));
        add_row(CMD_DIRTY, 0, 0, 4'd15, 1, mk(STAT_OK, 4'd15, 0));
        add_row(CMD_UNPIN, 0, 0, 4'd1, 1, mk(STAT_OK, 4'd1, 0));
        // dirty victim writes back
        add_row(CMD_FETCH, 16'h1234, 32'h5678_9abc, 0, 0, '0);
        add_row(CMD_DIRTY, 0, 0, 4'd0, 1, mk(STAT_OK, 4'd0, 0));
        add_row(CMD_FLUSH, 0, 0, 0, 0, '0);
        add_row(CMD_UNPIN, 0, 0, 4'd0, 0, '0);
        add_row(CMD_FETCH, 16'hffff, 32'hffff_ffff, 0, 0, '0);
        add_row(CMD_FETCH, 16'h1234, 32'h5678_9abc, 0, 0, '0);
        add_row(3'd5, 0, 0, 0, 0, '0);
        add_row(3'd7, 16'hffff, 32'hffff_ffff, 4'hf, 0, '0);
        add_row(CMD_FLUSH, 0, 0, 0, 0, '0);
        foreach (rows[i]) begin
            send_cmd(rows[i].cmd, rows[i].tab, rows[i].blk, rows[i].fi);
            // typed rows double-check the newest prediction
            if (rows[i].typed && expected_q.size() != 0 && expected_q[$] !== rows[i].res) begin
                $display("%0t: mismatch expected %h actual %h", $realtime,
                         rows[i].res, expected_q[$]);
                errors++;
            end
        end
        drain();

        // random phases across frame counts, extremes included
        src_idle_pct = 38; dst_idle_pct = 51;
        set_frames(5'd16);
        random_phase(80);
        drain();
        src_idle_pct = 51; dst_idle_pct = 38;
        set_frames(5'd1);
        random_phase(50);
        drain();
        set_frames(5'd31);
        random_phase(60);
        drain();
        src_idle_pct = 0; dst_idle_pct = 0;
        set_frames(5'd0);
        random_phase(20);
        drain();
        set_frames(5'd5);
        random_phase(80);
        drain();

        $display("run covered %0d commands and %0d results over frame counts 0..31",
                 tx_sent, results_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
